>>> rtl/llpb_pkg.sv
// package: formats, constant decode rom and encode threshold table for the pixel blend
`default_nettype none

package llpb_pkg;

  // fixed-point formats
  localparam int unsigned LINEAR_FRACTION_BITS = 16;
  localparam int unsigned WEIGHT_FRACTION_BITS = 16;

  // field widths of the channels
  localparam int unsigned PIXEL_W  = 32;
  localparam int unsigned WEIGHT_W = 17;

  // light value 0 .. 2^F inclusive
  localparam int unsigned LIN_W = LINEAR_FRACTION_BITS + 1;
  // weight 0 .. 2^W inclusive
  localparam int unsigned WT_W  = WEIGHT_FRACTION_BITS + 1;
  // colour products and their sum
  localparam int unsigned PROD_W = LIN_W + WT_W;
  // alpha products and their sum
  localparam int unsigned ALPHA_PROD_W = 8 + WT_W;

  localparam logic [WT_W-1:0]         WT_ONE     = WT_W'(1) << WEIGHT_FRACTION_BITS;
  localparam logic [LIN_W-1:0]        LIN_ONE    = LIN_W'(1) << LINEAR_FRACTION_BITS;
  localparam logic [PROD_W-1:0]       HALF       = PROD_W'(1) << (WEIGHT_FRACTION_BITS - 1);
  localparam logic [ALPHA_PROD_W-1:0] ALPHA_HALF =
    ALPHA_PROD_W'(1) << (WEIGHT_FRACTION_BITS - 1);

  typedef logic [LIN_W-1:0]             lin_t;
  typedef logic [255:0][LIN_W-1:0]      lin_rom_t;
  typedef logic [254:0][LIN_W-1:0]      thresh_rom_t;

  // register load enables of the pipeline stages
  typedef struct packed {
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
  } llpb_load_t;

  // table generation, evaluated at elaboration only
  localparam int unsigned KNEE_HALF_STEPS = 20;
  localparam longint unsigned LIN_DIVISOR  = 164730;
  localparam longint unsigned LIN_DIVISOR2 = 2 * 164730;
  localparam int unsigned CURVE_DENOM     = 10761;
  localparam int unsigned BN_W = 176 + 5 * (LINEAR_FRACTION_BITS + 2) + 16;

  typedef logic [BN_W-1:0] bn_t;

  function automatic bn_t bn_pow(bn_t base, int unsigned e);
    bn_t r;
    r = bn_t'(1);
    for (int i = 0; i < e; i++) begin
      r = r * base;
    end
    return r;
  endfunction

  // 2^F * (p/denom)^(12/5), rounded to nearest or rounded up
  function automatic lin_t curve_value(int unsigned p, bit want_round);
    bn_t rhs;
    bn_t d12;
    bn_t lhs;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    d12 = bn_pow(bn_t'(CURVE_DENOM), 12);
    rhs = bn_pow(bn_t'(p), 12) << (5 * LINEAR_FRACTION_BITS + (want_round ? 5 : 0));
    lo  = 0;
    if (want_round) begin
      hi = (1 << LINEAR_FRACTION_BITS) + 1;
      for (int it = 0; it < LINEAR_FRACTION_BITS + 3; it++) begin
        if (hi - lo > 1) begin
          mid = lo + (hi - lo) / 2;
          lhs = d12 * bn_pow(bn_t'(2 * mid - 1), 5);
          if (lhs <= rhs) lo = mid;
          else hi = mid;
        end
      end
      return lin_t'(lo);
    end
    hi = 1 << LINEAR_FRACTION_BITS;
    for (int it = 0; it < LINEAR_FRACTION_BITS + 3; it++) begin
      if (hi - lo > 1) begin
        mid = lo + (hi - lo) / 2;
        lhs = d12 * bn_pow(bn_t'(mid), 5);
        if (lhs >= rhs) hi = mid;
        else lo = mid;
      end
    end
    return lin_t'(hi);
  endfunction

  // light of encoded value n/510
  function automatic lin_t light_at(int unsigned n, bit want_round);
    longint unsigned num;
    if (n <= KNEE_HALF_STEPS) begin
      if (want_round) begin
        num = ((longint'(n) * 50) << LINEAR_FRACTION_BITS) + LIN_DIVISOR;
        return lin_t'(num / LIN_DIVISOR2);
      end
      num = ((longint'(n) * 25) << LINEAR_FRACTION_BITS) + LIN_DIVISOR - 1;
      return lin_t'(num / LIN_DIVISOR);
    end
    return curve_value(20 * n + 561, want_round);
  endfunction

  function automatic lin_rom_t build_rom();
    lin_rom_t r;
    for (int i = 0; i < 256; i++) begin
      r[i] = light_at(2 * i, 1'b1);
    end
    return r;
  endfunction

  function automatic thresh_rom_t build_thresh();
    thresh_rom_t r;
    for (int i = 1; i < 256; i++) begin
      r[i-1] = light_at(2 * i - 1, 1'b0);
    end
    return r;
  endfunction

  // code to light, and ascending thresholds between neighboring codes
  localparam lin_rom_t    LINEAR_ROM    = build_rom();
  localparam thresh_rom_t ENCODE_THRESH = build_thresh();

endpackage

`default_nettype wire

>>> rtl/llpb_if.sv
// interfaces: pixel pair input channel and blended pixel output channel
`default_nettype none

interface llpb_in_if import llpb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PIXEL_W-1:0]  pixel_first;
  logic [PIXEL_W-1:0]  pixel_second;
  logic [WEIGHT_W-1:0] blend_weight;

  modport source (output valid, pixel_first, pixel_second, blend_weight, input ready);
  modport sink   (input valid, pixel_first, pixel_second, blend_weight, output ready);
endinterface

interface llpb_out_if import llpb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_blended;

  modport source (output valid, pixel_blended, input ready);
  modport sink   (input valid, pixel_blended, output ready);
endinterface

`default_nettype wire

>>> rtl/llpb_lerp.sv
// decode to light and interpolate: product stage and round/clamp stage
`default_nettype none

module llpb_lerp import llpb_pkg::*; (
  input  wire logic               clk_i,
  input  wire llpb_load_t         load_i,
  input  wire logic [PIXEL_W-1:0] pixel_a_i,
  input  wire logic [PIXEL_W-1:0] pixel_b_i,
  input  wire logic [WT_W-1:0]    weight_i,
  output      lin_t [2:0]         lin_o,
  output      logic [7:0]         alpha_o
);

  logic [WT_W-1:0]         weight_inv;
  logic [PROD_W-1:0]       prod_a_d [3];
  logic [PROD_W-1:0]       prod_b_d [3];
  logic [PROD_W-1:0]       prod_a_q [3];
  logic [PROD_W-1:0]       prod_b_q [3];
  logic [ALPHA_PROD_W-1:0] alpha_a_d, alpha_b_d, alpha_a_q, alpha_b_q;
  logic [PROD_W-1:0]       sum_c [3];
  logic [PROD_W-1:0]       shifted [3];
  lin_t [2:0]              lin_d;
  lin_t [2:0]              lin_q;
  logic [ALPHA_PROD_W-1:0] alpha_sum;
  logic [7:0]              alpha_d, alpha_q;

  assign weight_inv = WT_ONE - weight_i;

  // rom lookup and weighting products
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_a_d[c] = PROD_W'(LINEAR_ROM[pixel_a_i[8*c +: 8]]) * PROD_W'(weight_inv);
      prod_b_d[c] = PROD_W'(LINEAR_ROM[pixel_b_i[8*c +: 8]]) * PROD_W'(weight_i);
    end
    alpha_a_d = ALPHA_PROD_W'(pixel_a_i[31:24]) * ALPHA_PROD_W'(weight_inv);
    alpha_b_d = ALPHA_PROD_W'(pixel_b_i[31:24]) * ALPHA_PROD_W'(weight_i);
  end

  always_ff @(posedge clk_i) begin
    if (load_i.ld2) begin
      prod_a_q  <= prod_a_d;
      prod_b_q  <= prod_b_d;
      alpha_a_q <= alpha_a_d;
      alpha_b_q <= alpha_b_d;
    end
  end

  // sum, round half up, clamp to one
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_c[c]   = prod_a_q[c] + prod_b_q[c] + HALF;
      shifted[c] = sum_c[c] >> WEIGHT_FRACTION_BITS;
      lin_d[c]   = (shifted[c] > PROD_W'(LIN_ONE)) ? LIN_ONE : shifted[c][LIN_W-1:0];
    end
    alpha_sum = alpha_a_q + alpha_b_q + ALPHA_HALF;
    alpha_d   = alpha_sum[WEIGHT_FRACTION_BITS +: 8];
  end

  always_ff @(posedge clk_i) begin
    if (load_i.ld3) begin
      lin_q   <= lin_d;
      alpha_q <= alpha_d;
    end
  end

  assign lin_o   = lin_q;
  assign alpha_o = alpha_q;

endmodule

`default_nettype wire

>>> rtl/llpb_encode.sv
// light to code: threshold search, high nibble then low nibble
`default_nettype none

module llpb_encode import llpb_pkg::*; (
  input  wire logic       clk_i,
  input  wire llpb_load_t load_i,
  input  wire lin_t       lin_i,
  output      logic [7:0] code_o
);

  logic [7:0] code_hi_d, code_hi_q;
  logic [7:0] code_lo_d, code_lo_q;
  logic [7:0] cand_hi, cand_lo;
  lin_t       lin_q;

  // high nibble: largest code whose threshold the light value reaches
  always_comb begin
    code_hi_d = '0;
    cand_hi   = '0;
    for (int b = 7; b >= 4; b--) begin
      cand_hi = code_hi_d | (8'b1 << b);
      if (lin_i >= ENCODE_THRESH[cand_hi - 8'd1]) code_hi_d = cand_hi;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.ld4) begin
      code_hi_q <= code_hi_d;
      lin_q     <= lin_i;
    end
  end

  // low nibble refines within the bracket
  always_comb begin
    code_lo_d = code_hi_q;
    cand_lo   = '0;
    for (int b = 3; b >= 0; b--) begin
      cand_lo = code_lo_d | (8'b1 << b);
      if (lin_q >= ENCODE_THRESH[cand_lo - 8'd1]) code_lo_d = cand_lo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.ld5) begin
      code_lo_q <= code_lo_d;
    end
  end

  assign code_o = code_lo_q;

endmodule

`default_nettype wire

>>> rtl/linear_light_pixel_blend.sv
// top level: linear-light blend of two argb8888 pixels, five-stage pipeline
//
// Input channel carries two ARGB8888 pixels and a Q1.16 blend weight toward the
// second pixel; weights above one are saturated to one. Output channel carries
// the blended pixel. Red, green and blue are decoded to light through a constant
// rom, interpolated, rounded and re-encoded by a binary search over constant
// thresholds; alpha is interpolated on its byte.
// Output valid is the valid bit of the last of five registers, in order: the
// input register, product register, round/clamp register, then two search
// registers (high and low nibble). One pixel pair is accepted per clock while
// the output is not stalled.
// Each stage holds a valid bit and loads whenever it is empty or the next stage
// takes its item, so bubbles fill up while the output is stalled. The input is
// refused only when all five stages hold items and the receiver is not ready.
// Reset clears all valid bits; the pipeline is empty afterwards and accepts in
// the first cycle out of reset.
`default_nettype none

module linear_light_pixel_blend import llpb_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  llpb_in_if.sink      in_if,
  llpb_out_if.source   out_if
);

  localparam int unsigned STAGES = 5;

  logic [STAGES-1:0] valid_q;
  logic [STAGES:0]   en;
  llpb_load_t        load;

  logic [PIXEL_W-1:0] pixel_a_q, pixel_b_q;
  logic [WT_W-1:0]    weight_d, weight_q;
  lin_t [2:0]         lin;
  logic [7:0]         alpha3;
  logic [7:0]         alpha4_q, alpha5_q;
  logic [7:0]         code [3];

  // per-stage advance: stage loads when empty or its item moves on
  always_comb begin
    en[STAGES] = out_if.ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign load.ld2 = en[1];
  assign load.ld3 = en[2];
  assign load.ld4 = en[3];
  assign load.ld5 = en[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_if.valid;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // input register with weight saturation
  assign weight_d = (WT_W'(in_if.blend_weight) > WT_ONE) ? WT_ONE :
                    WT_W'(in_if.blend_weight);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pixel_a_q <= in_if.pixel_first;
      pixel_b_q <= in_if.pixel_second;
      weight_q  <= weight_d;
    end
  end

  llpb_lerp u_lerp (
    .clk_i     (clk_i),
    .load_i    (load),
    .pixel_a_i (pixel_a_q),
    .pixel_b_i (pixel_b_q),
    .weight_i  (weight_q),
    .lin_o     (lin),
    .alpha_o   (alpha3)
  );

  for (genvar c = 0; c < 3; c++) begin : g_enc
    llpb_encode u_encode (
      .clk_i  (clk_i),
      .load_i (load),
      .lin_i  (lin[c]),
      .code_o (code[c])
    );
  end

  // alpha rides along with the search stages
  always_ff @(posedge clk_i) begin
    if (load.ld4) alpha4_q <= alpha3;
    if (load.ld5) alpha5_q <= alpha4_q;
  end

  assign in_if.ready          = en[0];
  assign out_if.valid         = valid_q[STAGES-1];
  assign out_if.pixel_blended = {alpha5_q, code[2], code[1], code[0]};

  // input refused only with a full pipeline and a stalled receiver
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> ((&valid_q) && !out_if.ready))
    else $error("input stalled while pipeline has room");

  // registered weight never exceeds one
  a_weight_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] |-> (weight_q <= WT_ONE))
    else $error("weight not saturated");

  // an item leaving stage one lands in stage two
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[0] && en[1]) |=> valid_q[1])
    else $error("item lost between stage one and two");

endmodule

`default_nettype wire

>>> tb/linear_light_pixel_blend_test.sv
// testbench: linear-light argb8888 blend checked against an independent table-driven predictor
`timescale 1ns / 100ps

module linear_light_pixel_blend_test;
  import llpb_pkg::*;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned RANDOM_PAIRS  = 650;
  localparam int unsigned QUIET_FROM    = 250;
  localparam int unsigned QUIET_TO      = 400;
  localparam int unsigned IDLE_PERCENT  = 9;
  localparam longint unsigned WEIGHT_ONE = longint'(1) << WEIGHT_FRACTION_BITS;
  localparam longint unsigned LIGHT_ONE  = longint'(1) << LINEAR_FRACTION_BITS;
  localparam int unsigned CURVE_DEN     = 10761;

  typedef logic [319:0] wide_t;

  typedef struct {
    logic [PIXEL_W-1:0]  pix_a;
    logic [PIXEL_W-1:0]  pix_b;
    logic [WEIGHT_W-1:0] weight;
    bit                  settle;  // hold off until every blended pixel is back
  } pixel_pair_t;

  logic clk_i;
  logic rst_ni;

  llpb_in_if  in_ch ();
  llpb_out_if out_ch ();

  linear_light_pixel_blend dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  pixel_pair_t        pixel_pairs[$];
  logic [PIXEL_W-1:0] blended_due[$];
  int unsigned        light_of_code[256];
  int unsigned        code_step_light[255];
  wide_t              den_pow12;
  int unsigned        error_count;
  int unsigned        pairs_sent;
  int unsigned        idle_run;
  bit                 pair_taken;

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic wide_t raise(wide_t base, int unsigned e);
    wide_t r;
    r = wide_t'(1);
    for (int i = 0; i < e; i++) r = r * base;
    return r;
  endfunction

  // light of encoded position n/510 in Q1.F, nearest or rounded up
  function automatic int unsigned light_bound(int unsigned n, bit nearest);
    longint unsigned num;
    int unsigned     p;
    int unsigned     v;
    real             est;
    wide_t           lim;
    if (n <= 20) begin
      if (nearest) begin
        num = ((longint'(n) * 50) << LINEAR_FRACTION_BITS) + 164730;
        return int'(num / 329460);
      end
      num = ((longint'(n) * 25) << LINEAR_FRACTION_BITS) + 164729;
      return int'(num / 164730);
    end
    // power curve ((20n+561)/10761)^2.4: float guess, then exact correction
    p   = 20 * n + 561;
    est = real'(LIGHT_ONE) * ((real'(p) / real'(CURVE_DEN)) ** 2.4);
    if (nearest) begin
      lim = raise(wide_t'(p), 12) << (5 * LINEAR_FRACTION_BITS + 5);
      v   = $rtoi(est + 0.5);
      if (v > LIGHT_ONE) v = LIGHT_ONE;
      while (v < LIGHT_ONE && raise(wide_t'(2 * v + 1), 5) * den_pow12 <= lim) v++;
      while (v > 0 && raise(wide_t'(2 * v - 1), 5) * den_pow12 > lim) v--;
      return v;
    end
    lim = raise(wide_t'(p), 12) << (5 * LINEAR_FRACTION_BITS);
    v   = $rtoi(est);
    if (v > LIGHT_ONE) v = LIGHT_ONE;
    while (v > 0 && raise(wide_t'(v - 1), 5) * den_pow12 >= lim) v--;
    while (v < LIGHT_ONE && raise(wide_t'(v), 5) * den_pow12 < lim) v++;
    return v;
  endfunction

  function automatic void build_light_tables();
    den_pow12 = raise(wide_t'(CURVE_DEN), 12);
    for (int i = 0; i < 256; i++) light_of_code[i] = light_bound(2 * i, 1'b1);
    for (int k = 1; k < 256; k++) code_step_light[k-1] = light_bound(2 * k - 1, 1'b0);
  endfunction

  // colour channel: decode, interpolate in light, round, clamp, re-encode
  function automatic logic [7:0] mix_in_light(logic [7:0] x, logic [7:0] y,
                                              longint unsigned t);
    longint unsigned s;
    longint unsigned lin;
    int unsigned     code;
    s   = longint'(light_of_code[x]) * (WEIGHT_ONE - t) + longint'(light_of_code[y]) * t;
    lin = (s + (WEIGHT_ONE >> 1)) >> WEIGHT_FRACTION_BITS;
    if (lin > LIGHT_ONE) lin = LIGHT_ONE;
    code = 0;
    for (int k = 0; k < 255; k++) if (lin >= code_step_light[k]) code++;
    return code[7:0];
  endfunction

  function automatic logic [PIXEL_W-1:0] blend_pixel(pixel_pair_t pp);
    longint unsigned     t;
    longint unsigned     s;
    longint unsigned     al;
    logic [PIXEL_W-1:0]  res;
    t = pp.weight;
    if (t > WEIGHT_ONE) t = WEIGHT_ONE;
    s  = longint'(pp.pix_a[31:24]) * (WEIGHT_ONE - t) + longint'(pp.pix_b[31:24]) * t;
    al = (s + (WEIGHT_ONE >> 1)) >> WEIGHT_FRACTION_BITS;
    if (al > 255) al = 255;
    res[31:24] = al[7:0];
    for (int c = 0; c < 3; c++)
      res[8*c +: 8] = mix_in_light(pp.pix_a[8*c +: 8], pp.pix_b[8*c +: 8], t);
    return res;
  endfunction

  function automatic void queue_pair(logic [31:0] a, logic [31:0] b,
                                     logic [WEIGHT_W-1:0] w, bit settle);
    pixel_pair_t pp;
    pp.pix_a  = a;
    pp.pix_b  = b;
    pp.weight = w;
    pp.settle = settle;
    pixel_pairs.push_back(pp);
  endfunction

  function automatic logic [31:0] rand_pixel();
    logic [31:0] p;
    p = $urandom;
    for (int c = 0; c < 4; c++) begin
      case ($urandom_range(15))
        0: p[8*c +: 8] = 8'h00;
        1: p[8*c +: 8] = 8'hff;
        2: p[8*c +: 8] = 8'($urandom_range(12));  // near black, across the end of the linear segment
        default: ;
      endcase
    end
    return p;
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(9))
      0: return '0;
      1: return WEIGHT_W'(WEIGHT_ONE);
      2: return WEIGHT_W'($urandom_range(131071, 65537));  // saturates to one
      3: return WEIGHT_W'($urandom_range(255));
      4: return WEIGHT_W'(WEIGHT_ONE - $urandom_range(255));
      default: return WEIGHT_W'($urandom_range(65536));
    endcase
  endfunction

  // stimulus, reset and end of run
  initial begin
    logic [31:0] a;
    logic [31:0] b;
    int unsigned ch;
    in_ch.valid        = 1'b0;
    in_ch.pixel_first  = '0;
    in_ch.pixel_second = '0;
    in_ch.blend_weight = '0;
    out_ch.ready       = 1'b0;
    rst_ni             = 1'b0;
    error_count        = 0;
    build_light_tables();

    // directed: weight extremes, saturation, equal codes, near-black codes
    queue_pair(32'h0000_0000, 32'hffff_ffff, 17'h00000, 1'b0);
    queue_pair(32'h0000_0000, 32'hffff_ffff, 17'h10000, 1'b0);
    queue_pair(32'h0000_0000, 32'hffff_ffff, 17'h08000, 1'b0);
    queue_pair(32'hffff_ffff, 32'h0000_0000, 17'h08000, 1'b0);
    queue_pair(32'h0000_0000, 32'hffff_ffff, 17'h00001, 1'b0);
    queue_pair(32'h0000_0000, 32'hffff_ffff, 17'h0ffff, 1'b0);
    queue_pair(32'h1234_5678, 32'h9abc_def0, 17'h1ffff, 1'b0);
    queue_pair(32'h1234_5678, 32'h9abc_def0, 17'h10001, 1'b0);
    queue_pair(32'h1234_5678, 32'h9abc_def0, 17'h00000, 1'b0);
    queue_pair(32'h8080_8080, 32'h8080_8080, 17'h03039, 1'b0);
    queue_pair(32'h0a0b_0c0d, 32'h0000_0000, 17'h08000, 1'b0);
    queue_pair(32'hff0a_1428, 32'h0014_1e0a, 17'h04e20, 1'b0);
    queue_pair(32'h0102_0304, 32'hfdfe_ff00, 17'h0aaaa, 1'b0);
    queue_pair(32'h7f80_7f80, 32'h807f_807f, 17'h05555, 1'b0);
    queue_pair(32'hffff_ffff, 32'hffff_ffff, 17'h1ffff, 1'b0);
    queue_pair(32'h0000_0000, 32'h0000_0000, 17'h08000, 1'b0);

    // random pairs, some channels shared between the two pixels
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      a = rand_pixel();
      b = rand_pixel();
      if ($urandom_range(5) == 0) begin
        ch = $urandom_range(3);
        b[8*ch +: 8] = a[8*ch +: 8];
      end
      queue_pair(a, b, rand_weight(), i == 0 || i == 420);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pixel_pairs.size() != 0 || blended_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("linear_light_pixel_blend regression: pass");
    end else begin
      $display("linear_light_pixel_blend regression: fail");
    end
    $finish;
  end

  // driver: presents pairs at the falling edge, holds each until its transfer
  always @(negedge clk_i) begin : drive_pairs
    bit hold;
    bit quiet;
    bit go;
    if (rst_ni) begin
      if (in_ch.valid && pair_taken) void'(pixel_pairs.pop_front());
      quiet = pairs_sent >= QUIET_FROM && pairs_sent < QUIET_TO;
      hold  = in_ch.valid && !pair_taken;
      if (!hold) begin
        go = pixel_pairs.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PERCENT);
        if (go && pixel_pairs[0].settle && blended_due.size() != 0) go = 1'b0;
        in_ch.valid <= go;
        if (go) begin
          in_ch.pixel_first  <= pixel_pairs[0].pix_a;
          in_ch.pixel_second <= pixel_pairs[0].pix_b;
          in_ch.blend_weight <= pixel_pairs[0].weight;
        end
      end
      out_ch.ready <= quiet || $urandom_range(99) >= IDLE_PERCENT;
    end
  end

  // monitor: records input transfers, checks output transfers in order
  always @(posedge clk_i) begin : watch_transfers
    pixel_pair_t        pp;
    logic [PIXEL_W-1:0] want;
    if (!rst_ni) begin
      pair_taken <= 1'b0;
      pairs_sent <= 0;
      idle_run   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (blended_due.size() == 0) begin
          error_count++;
          $display("%0t: blended pixel with none expected: expected none, actual %h",
                   $time, out_ch.pixel_blended);
        end else begin
          want = blended_due.pop_front();
          if (out_ch.pixel_blended !== want) begin
            error_count++;
            $display("%0t: pixel_blended mismatch: expected %h, actual %h",
                     $time, want, out_ch.pixel_blended);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pp.pix_a  = in_ch.pixel_first;
        pp.pix_b  = in_ch.pixel_second;
        pp.weight = in_ch.blend_weight;
        pp.settle = 1'b0;
        blended_due.push_back(blend_pixel(pp));
        pairs_sent <= pairs_sent + 1;
      end
      pair_taken <= in_ch.valid && in_ch.ready;
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_run <= 0;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (idle_run >= STALL_LIMIT) begin
      $display("linear_light_pixel_blend regression: fail");
      $finish;
    end
  end

endmodule

>>> files.f
rtl/llpb_pkg.sv
rtl/llpb_if.sv
rtl/llpb_lerp.sv
rtl/llpb_encode.sv
rtl/linear_light_pixel_blend.sv
tb/linear_light_pixel_blend_test.sv
